/* sv/thp_pkg.sv */
// thp_pkg: shared types, record layout constants and character tables
// for the tar header parser; no dependencies
package thp_pkg;

	// record geometry
	localparam int RECORD_BYTES = 512;
	localparam int POS_W = $clog2(RECORD_BYTES);
	localparam int SPAN_W = 33;

	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_LAST = pos_t'(RECORD_BYTES - 1);

	// header field offsets
	localparam pos_t LINK_LAST = pos_t'(13);
	localparam pos_t SIZE_FIRST = pos_t'(124);
	localparam pos_t SIZE_LAST = pos_t'(135);
	localparam pos_t TIME_FIRST = pos_t'(136);
	localparam pos_t TIME_LAST = pos_t'(147);
	localparam pos_t TYPE_OFF = pos_t'(156);
	localparam pos_t MAGIC_FIRST = pos_t'(257);
	localparam pos_t MAGIC_LAST = pos_t'(261);

	localparam logic [SPAN_W-1:0] SPAN_ROUND = SPAN_W'(RECORD_BYTES - 1);

	// record sequencing
	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_SKIP   = 2'd1,
		PH_META   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_END       = 2'd1,
		ST_BAD_TYPE  = 2'd2,
		ST_BAD_MAGIC = 2'd3
	} status_t;

	// per-record flags
	typedef struct packed {
		logic all_zero;
		logic magic_empty;
		logic longlink;
		logic magic_bad;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{all_zero: 1'b1, magic_empty: 1'b1,
		longlink: 1'b1, magic_bad: 1'b0};

	// one parsed header
	typedef struct packed {
		logic [31:0]       size;
		logic [31:0]       mtime;
		logic [7:0]        ftype;
		logic [SPAN_W-1:0] span;
		logic              long_name;
		status_t           status;
	} entry_t;

	// expected name bytes of a long-name marker record, NUL after the text
	function automatic logic [7:0] link_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h2E; // .
			4'd1:    c = 8'h2F; // /
			4'd2:    c = 8'h2E;
			4'd3:    c = 8'h2F;
			4'd4:    c = 8'h40; // @
			4'd5:    c = 8'h6C; // l
			4'd6:    c = 8'h6F; // o
			4'd7:    c = 8'h6E; // n
			4'd8:    c = 8'h67; // g
			4'd9:    c = 8'h6C; // l
			4'd10:   c = 8'h69; // i
			4'd11:   c = 8'h6E; // n
			4'd12:   c = 8'h6B; // k
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// ustar magic bytes
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h75; // u
			3'd1:    c = 8'h73; // s
			3'd2:    c = 8'h74; // t
			3'd3:    c = 8'h61; // a
			3'd4:    c = 8'h72; // r
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// lower-case letters, backslash read as slash
	function automatic logic [7:0] fold_char(input logic [7:0] b);
		logic [7:0] n;
		n = b;
		if (b == 8'h5C)
			n = 8'h2F;
		else if (b >= 8'h41 && b <= 8'h5A)
			n = b + 8'h20;
		return n;
	endfunction

	function automatic logic is_octal(input logic [7:0] b);
		return b[7:3] == 5'b00110;
	endfunction

	// digits 0-7, NUL or x
	function automatic logic type_ok(input logic [7:0] t);
		return is_octal(t) || t == 8'h00 || t == 8'h78;
	endfunction

endpackage

/* sv/thp_track.sv */
// thp_track: record position counter, field parsers and record sequencing
// depends on thp_pkg
module thp_track import thp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] byte_in,
	output logic       emit_req,
	output entry_t     entry
);

	pos_t        pos_q;
	phase_t      phase_q, phase_n;
	logic [31:0] size_q, size_n;
	logic        size_stop_q, size_stop_n;
	logic [31:0] time_q, time_n;
	logic        time_stop_q, time_stop_n;
	logic [7:0]  type_q, type_n;
	flags_t      flags_q, flags_n;
	logic        last;
	logic [7:0]  want;

	assign last = pos_q == POS_LAST;
	assign want = link_char(pos_q[3:0]);

	// field updates for the current byte
	always_comb begin
		flags_n = flags_q;
		size_n = size_q;
		size_stop_n = size_stop_q;
		time_n = time_q;
		time_stop_n = time_stop_q;
		type_n = type_q;
		if (byte_in != 8'h00)
			flags_n.all_zero = 1'b0;
		if (pos_q <= LINK_LAST && fold_char(byte_in) != want)
			flags_n.longlink = 1'b0;
		if (pos_q >= SIZE_FIRST && pos_q <= SIZE_LAST && !size_stop_q) begin
			if (is_octal(byte_in))
				size_n = {size_q[28:0], byte_in[2:0]};
			else
				size_stop_n = 1'b1;
		end
		if (pos_q >= TIME_FIRST && pos_q <= TIME_LAST && !time_stop_q) begin
			if (is_octal(byte_in))
				time_n = {time_q[28:0], byte_in[2:0]};
			else
				time_stop_n = 1'b1;
		end
		if (pos_q == TYPE_OFF)
			type_n = byte_in;
		if (pos_q == MAGIC_FIRST && byte_in != 8'h00)
			flags_n.magic_empty = 1'b0;
		if (pos_q >= MAGIC_FIRST && pos_q <= MAGIC_LAST &&
				byte_in != magic_char(3'(pos_q - MAGIC_FIRST)))
			flags_n.magic_bad = 1'b1;
	end

	// next record phase
	always_comb begin
		phase_n = phase_q;
		if (last) begin
			unique case (phase_q)
				PH_SKIP: phase_n = PH_META;
				PH_META: phase_n = PH_NORMAL;
				default: phase_n = flags_n.longlink ? PH_SKIP : PH_NORMAL;
			endcase
		end
	end

	// result of a finished header record
	always_comb begin
		emit_req = last && phase_q != PH_SKIP &&
			!(phase_q != PH_META && flags_n.longlink);
		entry.size = size_n;
		entry.mtime = (time_n == 32'd0) ? 32'd1 : time_n;
		entry.ftype = type_n;
		entry.span = ({1'b0, size_n} + SPAN_ROUND) & ~SPAN_ROUND;
		entry.long_name = phase_q == PH_META;
		priority if (flags_n.all_zero)
			entry.status = ST_END;
		else if (!type_ok(type_n))
			entry.status = ST_BAD_TYPE;
		else if (!flags_n.magic_empty && flags_n.magic_bad)
			entry.status = ST_BAD_MAGIC;
		else
			entry.status = ST_VALID;
	end

	// state registers; position, fields and flags cleared at every record boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_NORMAL;
			size_q <= '0;
			size_stop_q <= 1'b0;
			time_q <= '0;
			time_stop_q <= 1'b0;
			type_q <= '0;
			flags_q <= FLAGS_RESET;
		end else if (adv) begin
			phase_q <= phase_n;
			if (last) begin
				pos_q <= '0;
				size_q <= '0;
				size_stop_q <= 1'b0;
				time_q <= '0;
				time_stop_q <= 1'b0;
				type_q <= '0;
				flags_q <= FLAGS_RESET;
			end else begin
				pos_q <= pos_q + pos_t'(1);
				size_q <= size_n;
				size_stop_q <= size_stop_n;
				time_q <= time_n;
				time_stop_q <= time_stop_n;
				type_q <= type_n;
				flags_q <= flags_n;
			end
		end
	end

	// a finished record leaves clean per-record state
	a_record_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last |=> pos_q == '0 && flags_q == FLAGS_RESET &&
			!size_stop_q && !time_stop_q && type_q == 8'h00)
		else $error("per-record state not cleared at record end");

	// the skipped name record is always followed by the metadata record
	a_skip_to_meta: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last && phase_q == PH_SKIP |=> phase_q == PH_META && !emit_req)
		else $error("long-name record not followed by metadata phase");

	// every emitted header returns to normal sequencing
	a_emit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit_req |=> phase_q == PH_NORMAL)
		else $error("phase not normal after header result");

endmodule

/* sv/thp_out_reg.sv */
// thp_out_reg: result register with valid/stall handshake toward the consumer
// depends on thp_pkg
module thp_out_reg import thp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  entry_t entry_in,
	input  logic   stall,
	output logic   valid,
	output entry_t entry_q
);

	logic valid_q;

	assign valid = valid_q;

	// valid flag: set on load, dropped once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			entry_q <= entry_in;
	end

endmodule

/* sv/tar_header_parser_core.sv */
// tar_header_parser_core: one header byte per cycle; a result word for every
// parsed header record, carried in a result register.
// The record's last byte is accepted into the input register; the result word
// is then loaded into the result register.
// Throughput: 1 byte per cycle; the input stalls only when a finishing
// record meets a full, stalled result register.
// Reset clears record position, phase, per-record flags and both valid flags.
module tar_header_parser_core import thp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              data_valid,
	output logic              data_stall,
	input  logic [7:0]        data_byte,
	output logic              entry_valid,
	input  logic              entry_stall,
	output logic [31:0]       entry_size,
	output logic [31:0]       entry_time,
	output logic [7:0]        entry_type,
	output logic [SPAN_W-1:0] data_span,
	output logic              long_name,
	output logic [1:0]        status
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       emit_req;
	logic       hold;
	logic       adv;
	logic       load;
	logic       accept;
	entry_t     entry;
	entry_t     entry_q;

	// input stage handshake
	assign hold = emit_req && entry_valid && entry_stall;
	assign adv = valid_s1 && !hold;
	assign load = adv && emit_req;
	assign data_stall = valid_s1 && hold;
	assign accept = data_valid && !data_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			data_byte_s1 <= data_byte;
	end

	// record parsing
	thp_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.byte_in  (data_byte_s1),
		.emit_req (emit_req),
		.entry    (entry)
	);

	// result register
	thp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.entry_in (entry),
		.stall    (entry_stall),
		.valid    (entry_valid),
		.entry_q  (entry_q)
	);

	assign entry_size = entry_q.size;
	assign entry_time = entry_q.mtime;
	assign entry_type = entry_q.ftype;
	assign data_span = entry_q.span;
	assign long_name = entry_q.long_name;
	assign status = entry_q.status;

	// a waiting result word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid && entry_stall |-> !load)
		else $error("result word overwritten while stalled");

endmodule
